FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant violated");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication violated");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication violated");

`endif

FILE: rtl/core/hsfd_pkg.sv
`timescale 1ns / 1ps

package hsfd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned FRAME_LEN   = 6;
   localparam int unsigned STORE_DEPTH = 5;
   localparam int unsigned POS_W       = 3;

   localparam logic [POS_W-1:0] POS_FIRST  = 3'd0;
   localparam logic [POS_W-1:0] POS_CRC_T  = 3'd2;
   localparam logic [POS_W-1:0] POS_LAST   = 3'd5;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam int unsigned BUSY_BIT = 7;

   // configuration port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_SENSOR_KIND = 1'b0;

   // 16-bit word frame scaling
   localparam logic [14:0] T0_SCALE  = 15'd17500;
   localparam logic [14:0] T0_OFFSET = 15'd4500;
   localparam logic [14:0] H0_SCALE  = 15'd12500;
   localparam logic [15:0] H0_OFFSET = 16'd600;
   localparam logic [16:0] WORD_MAX  = 17'd65535;

   // 20-bit packed frame scaling
   localparam logic [14:0] T1_SCALE  = 15'd20000;
   localparam logic [14:0] T1_OFFSET = 15'd5000;
   localparam logic [13:0] H1_SCALE  = 14'd10000;

   localparam logic [13:0] H_MAX     = 14'd10000;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_CRC_ERR = 2'd1,
      STATUS_BUSY    = 2'd2
   } status_type;

   typedef struct packed {
      logic                   last;
      logic                   crc_bad;
      logic [5:0][BYTE_W-1:0] bytes;
   } frame_info_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

FILE: rtl/core/hsfd_frame.sv
`timescale 1ns / 1ps

module hsfd_frame (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  logic [7:0]              data_byte,
   input  logic                    frame_start,
   output hsfd_pkg::frame_info_type info
);
   import hsfd_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in, pos;
   logic [7:0]        crc_ff, crc_in, crc_base;
   logic              fail_ff, fail_in, fail_base;
   logic [BYTE_W-1:0] bytes_ff [STORE_DEPTH];

   always_comb begin
      // resync on frame start or on an out-of-range position
      if (frame_start || (pos_ff >= POS_W'(FRAME_LEN))) begin
         pos = POS_FIRST;
      end else begin
         pos = pos_ff;
      end
      crc_base  = (pos == POS_FIRST) ? CRC_INIT : crc_ff;
      fail_base = (pos == POS_FIRST) ? 1'b0 : fail_ff;
      if ((pos == POS_CRC_T) || (pos == POS_LAST)) begin
         fail_in = fail_base | (crc_base != data_byte);
         crc_in  = CRC_INIT;
      end else begin
         fail_in = fail_base;
         crc_in  = crc8_update(crc_base, data_byte);
      end
      pos_in = (pos == POS_LAST) ? POS_FIRST : pos + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_FIRST;
         crc_ff  <= CRC_INIT;
         fail_ff <= 1'b0;
      end else if (step) begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         fail_ff <= fail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && (pos < POS_W'(STORE_DEPTH))) begin
         bytes_ff[pos] <= data_byte;
      end
   end

   always_comb begin
      info.last    = (pos == POS_LAST);
      info.crc_bad = fail_in;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         info.bytes[i] = bytes_ff[i];
      end
      info.bytes[FRAME_LEN-1] = data_byte;
   end

endmodule

FILE: rtl/core/hsfd_convert.sv
`timescale 1ns / 1ps

module hsfd_convert (
   input  hsfd_pkg::frame_info_type info,
   input  logic                     sensor_kind,
   output hsfd_pkg::status_type     status,
   output logic signed [14:0]       temperature_centi,
   output logic [13:0]              humidity_centi
);
   import hsfd_pkg::*;

   logic [15:0] t0, h0;
   logic [30:0] prod_t0, prod_h0;
   logic [14:0] q_t0, q_h0;
   logic [15:0] hum0_raw;
   logic [19:0] t1, h1;
   logic [33:0] prod_h1;
   logic [34:0] prod_t1;
   logic [14:0] q_t1;

   // floor(x / 65535): x = q0*65535 + (lo + q0), remainder stays below 2*65535
   function automatic logic [14:0] div_word_max(input logic [30:0] x);
      logic [14:0] q0;
      logic [16:0] r;
      q0 = x[30:16];
      r  = 17'(x[15:0]) + 17'(q0);
      return q0 + 15'(r >= WORD_MAX);
   endfunction

   always_comb begin
      t0       = {info.bytes[0], info.bytes[1]};
      h0       = {info.bytes[3], info.bytes[4]};
      prod_t0  = 31'(t0) * 31'(T0_SCALE);
      prod_h0  = 31'(h0) * 31'(H0_SCALE);
      q_t0     = div_word_max(prod_t0);
      q_h0     = div_word_max(prod_h0);
      hum0_raw = 16'(q_h0) - H0_OFFSET;

      h1       = {info.bytes[1], info.bytes[2], info.bytes[3][7:4]};
      t1       = {info.bytes[3][3:0], info.bytes[4], info.bytes[5]};
      prod_h1  = 34'(h1) * 34'(H1_SCALE);
      prod_t1  = 35'(t1) * 35'(T1_SCALE);
      q_t1     = prod_t1[34:20];

      status            = STATUS_OK;
      temperature_centi = '0;
      humidity_centi    = '0;
      if (!sensor_kind) begin
         if (info.crc_bad) begin
            status = STATUS_CRC_ERR;
         end else begin
            temperature_centi = $signed(q_t0 - T0_OFFSET);
            // clamp to 0..10000
            if (hum0_raw[15]) begin
               humidity_centi = '0;
            end else if (hum0_raw > 16'(H_MAX)) begin
               humidity_centi = H_MAX;
            end else begin
               humidity_centi = hum0_raw[13:0];
            end
         end
      end else begin
         if (info.bytes[0][BUSY_BIT]) begin
            status = STATUS_BUSY;
         end else begin
            temperature_centi = $signed(q_t1 - T1_OFFSET);
            humidity_centi    = prod_h1[33:20];
         end
      end
   end

endmodule

FILE: rtl/core/humidity_sensor_frame_decoder_unit.sv
`timescale 1ns / 1ps
// Sensor frame decoder.
// req_*: one raw response byte per word; req_tuser marks the first byte of a
//   frame and resets the byte counter, dropping any partial frame.
// rsp_*: one word per six-byte frame with status (ok, CRC error, busy) and
//   temperature / humidity in hundredths; error words carry zero readings.
// csr_*: APB-style port, register 0 bit 0 = sensor_kind (0 = 16-bit words
//   with CRC-8, 1 = busy flag and 20-bit packed words). Write only while idle.
// Throughput: one byte per cycle unless a frame-ending byte is held (see Stall).
//   Each byte lands in an input register and is decoded from there; the sixth
//   byte's result is loaded into the result register, which drives rsp_tvalid.
// Stall: the result register holds the word until rsp_tready; meanwhile
//   bytes that do not complete a frame keep flowing, and a frame-ending byte
//   waits in the input register, which then deasserts req_tready.
// Reset: clears the byte counter, CRC state, kind register and valid flags.
`include "assert_macros.svh"

module humidity_sensor_frame_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] status, [16:2] temperature_centi,
                                    // [30:17] humidity_centi, [31] zero
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [hsfd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [hsfd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [hsfd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import hsfd_pkg::*;

   logic              kind_ff, kind_in;
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_start_ff;
   logic              advance;
   frame_info_type    info;
   status_type        cv_status;
   logic signed [14:0] cv_temp;
   logic [13:0]       cv_hum;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic signed [14:0] rsp_temp_ff;
   logic [13:0]       rsp_hum_ff;
   logic              csr_hit;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_SENSOR_KIND);
   assign csr_prdata = csr_hit ? CSR_DATA_W'(kind_ff) : '0;

   always_comb begin
      kind_in = kind_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         kind_in = csr_pwdata[0];
      end
   end

   // input register; a frame-ending byte waits for a free result slot
   assign advance    = s1_valid_ff && (!info.last || !rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         kind_ff     <= kind_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff  <= req_tdata;
         s1_start_ff <= req_tuser;
      end
   end

   hsfd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .data_byte   (s1_byte_ff),
      .frame_start (s1_start_ff),
      .info        (info)
   );

   hsfd_convert u_convert (
      .info              (info),
      .sensor_kind       (kind_ff),
      .status            (cv_status),
      .temperature_centi (cv_temp),
      .humidity_centi    (cv_hum)
   );

   // result register
   always_comb begin
      if (advance && info.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && info.last) begin
         rsp_status_ff <= cv_status;
         rsp_temp_ff   <= cv_temp;
         rsp_hum_ff    <= cv_hum;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_hum_ff, rsp_temp_ff, rsp_status_ff};

   `ASSERT_IMPLIES(a_error_zero_readings, clock, reset, rsp_valid_ff && (rsp_status_ff != STATUS_OK), (rsp_temp_ff == '0) && (rsp_hum_ff == '0))
   `ASSERT_ALWAYS(a_humidity_in_range, clock, reset, !rsp_valid_ff || (rsp_hum_ff <= H_MAX))
   `ASSERT_NEXT(a_frame_end_loads_result, clock, reset, advance && info.last, rsp_valid_ff)
   `ASSERT_NEXT(a_blocked_byte_held, clock, reset, s1_valid_ff && !advance, s1_valid_ff)

endmodule
